>>> hdl/slm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg - session link manager shared definitions
// Event opcodes, session states, error codes, register indexes and the
// structs that travel between the top level, the sequencer and the ALU.
// ----------------------------------------------------------------------------
package slm_pkg;

   // event opcodes
   localparam logic [3:0] OP_TICK    = 4'd0;
   localparam logic [3:0] OP_LINK    = 4'd1;
   localparam logic [3:0] OP_CRED    = 4'd2;
   localparam logic [3:0] OP_DEVID   = 4'd3;
   localparam logic [3:0] OP_REQUEST = 4'd4;
   localparam logic [3:0] OP_BEGIN   = 4'd5;
   localparam logic [3:0] OP_UP      = 4'd6;
   localparam logic [3:0] OP_AUTH    = 4'd7;
   localparam logic [3:0] OP_FAIL    = 4'd8;
   localparam logic [3:0] OP_DISC    = 4'd9;
   localparam logic [3:0] OP_EXPIRE  = 4'd10;
   localparam logic [3:0] OP_APPLY   = 4'd11;

   // session states
   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_UNCONF     = 4'd1;
   localparam logic [3:0] ST_CONF       = 4'd2;
   localparam logic [3:0] ST_OFFLINE    = 4'd3;
   localparam logic [3:0] ST_REQ        = 4'd4;
   localparam logic [3:0] ST_CONNECTING = 4'd5;
   localparam logic [3:0] ST_AUTHING    = 4'd6;
   localparam logic [3:0] ST_READY      = 4'd7;
   localparam logic [3:0] ST_DEGRADED   = 4'd8;
   localparam logic [3:0] ST_BACKOFF    = 4'd9;
   localparam logic [3:0] ST_ERROR      = 4'd10;

   // error codes
   localparam logic [3:0] ER_NONE     = 4'd0;
   localparam logic [3:0] ER_INVALID  = 4'd1;
   localparam logic [3:0] ER_NOTCONF  = 4'd2;
   localparam logic [3:0] ER_NONET    = 4'd3;
   localparam logic [3:0] ER_NOINET   = 4'd4;
   localparam logic [3:0] ER_NOID     = 4'd5;
   localparam logic [3:0] ER_NOCRED   = 4'd6;
   localparam logic [3:0] ER_DNS      = 4'd7;
   localparam logic [3:0] ER_CONNECT  = 4'd8;
   localparam logic [3:0] ER_TLS      = 4'd9;
   localparam logic [3:0] ER_AUTH     = 4'd10;
   localparam logic [3:0] ER_EXPIRED  = 4'd11;
   localparam logic [3:0] ER_RATE     = 4'd12;
   localparam logic [3:0] ER_SERVER   = 4'd13;
   localparam logic [3:0] ER_PROTOCOL = 4'd14;
   localparam logic [3:0] ER_INTERNAL = 4'd15;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_URL    = 3'd5;

   // setting defaults and normalization values
   localparam logic [7:0]  DEF_LIMIT = 8'd3;
   localparam logic [31:0] DEF_BASE  = 32'd1000;
   localparam logic [31:0] DEF_MAX   = 32'd10000;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 216;

   typedef struct packed {
      logic        en;
      logic        auto_conn;
      logic [7:0]  lim;
      logic [31:0] base;
      logic [31:0] max_d;
      logic        url;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  opcode;
      logic        flag_first;
      logic        flag_second;
      logic [3:0]  error_code;
      logic [31:0] now_ms;
   } evt_type;

   typedef struct packed {
      logic [3:0]  session_state;
      logic [3:0]  last_error;
      logic [31:0] generation;
      logic        accepted;
      logic        is_ready;
      logic        should_connect;
      logic [7:0]  retry_count;
      logic [31:0] retry_wait_ms;
      logic [31:0] retry_due_time;
      logic [31:0] failures;
      logic [31:0] connects;
      logic [31:0] sessions;
   } rsp_type;

   typedef struct packed {
      logic [32:0] a;
      logic [32:0] b;
      logic [32:0] c;
   } alu_req_type;

   typedef struct packed {
      logic [32:0] sum;
      logic        lt;
      logic        eq;
   } alu_rsp_type;

endpackage

>>> hdl/slm_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_alu - shared add and compare unit
// One 33-bit adder plus a magnitude compare of operand a against c; the
// sequencer steers it for generation bumps, totals, doubling and due time.
// ----------------------------------------------------------------------------
module slm_alu (
   input  slm_pkg::alu_req_type req,
   output slm_pkg::alu_rsp_type rsp
);
   import slm_pkg::*;

   assign rsp.sum = req.a + req.b;
   assign rsp.lt  = req.a < req.c;
   assign rsp.eq  = req.a == req.c;

endmodule

>>> hdl/slm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_core - session sequencer
// Holds the session machine, active settings and retry bookkeeping, decides
// one event, then walks the shared ALU through the arithmetic it needs.
// ----------------------------------------------------------------------------
module slm_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  slm_pkg::evt_type evt,
   input  slm_pkg::cfg_type staged,
   input  logic             out_free,
   output logic             ready,
   output logic             res_valid,
   output slm_pkg::rsp_type res
);
   import slm_pkg::*;

   localparam logic [2:0] SEQ_IDLE   = 3'd0;
   localparam logic [2:0] SEQ_DECIDE = 3'd1;
   localparam logic [2:0] SEQ_GEN    = 3'd2;
   localparam logic [2:0] SEQ_CNT    = 3'd3;
   localparam logic [2:0] SEQ_DBL    = 3'd4;
   localparam logic [2:0] SEQ_DUE    = 3'd5;
   localparam logic [2:0] SEQ_DONE   = 3'd6;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_FAIL = 2'd1;
   localparam logic [1:0] CNT_CONN = 2'd2;
   localparam logic [1:0] CNT_SESS = 2'd3;

   typedef struct packed {
      logic [3:0] st;
      logic [3:0] er;
      logic [1:0] nb;    // pending generation bumps
      logic       net;
      logic       inet;
      logic       cred;
      logic       devid;
      logic       pend;
      logic       link;
      logic       auth;
      logic       sup;
      logic       acc;   // helper return, then the accepted flag
      logic       bo;    // start backoff arithmetic
   } sess_type;

   logic [2:0]  seq_ff, seq_in;
   evt_type     evt_ff, evt_in;
   cfg_type     act_ff, act_in;
   sess_type    sess_ff, sess_in;
   logic [31:0] gen_ff, gen_in;
   logic [31:0] fail_ff, fail_in;
   logic [31:0] conn_ff, conn_in;
   logic [31:0] stot_ff, stot_in;
   logic [7:0]  attempt_ff, attempt_in;
   logic [31:0] delay_ff, delay_in;
   logic [31:0] due_ff, due_in;
   logic [31:0] time_ff, time_in;
   logic [1:0]  cnt_sel_ff, cnt_sel_in;
   logic [32:0] work_d_ff, work_d_in;
   logic [7:0]  work_cnt_ff, work_cnt_in;

   sess_type    dec_sess;
   cfg_type     dec_act;
   logic [1:0]  dec_cnt_sel;
   logic        dec_clr;
   logic        dec_tick_clr;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   slm_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // ---------------------------------------------------------------------
   // session helpers
   // ---------------------------------------------------------------------
   function automatic sess_type f_go(sess_type s, logic [3:0] st, logic [3:0] er);
      sess_type r;
      r = s;
      if (r.st != st || r.er != er) begin
         r.st = st;
         r.er = er;
         r.nb = r.nb + 2'd1;
      end
      return r;
   endfunction

   function automatic sess_type f_drop(sess_type s);
      sess_type r;
      r      = s;
      r.pend = 1'b0;
      r.link = 1'b0;
      r.auth = 1'b0;
      r.sup  = 1'b0;
      return r;
   endfunction

   function automatic logic f_cfgd(cfg_type a);
      return !a.en || a.url;
   endfunction

   function automatic logic f_auto_ok(sess_type s, cfg_type a);
      return a.auto_conn && f_cfgd(a) && s.net && s.inet && s.devid && s.cred;
   endfunction

   // prerequisite chain; acc reports that nothing blocks
   function automatic sess_type f_prereq(sess_type s, logic clear, cfg_type a);
      sess_type   r;
      logic       blk;
      logic [3:0] st;
      logic [3:0] er;
      r   = s;
      blk = 1'b1;
      st  = ST_IDLE;
      er  = ER_NONE;
      priority if (!a.en) begin
         st = ST_IDLE;    er = ER_NONE;
      end else if (!f_cfgd(a)) begin
         st = ST_UNCONF;  er = ER_NOTCONF;
      end else if (!r.net) begin
         st = ST_OFFLINE; er = ER_NONET;
      end else if (!r.inet) begin
         st = ST_OFFLINE; er = ER_NOINET;
      end else if (!r.devid) begin
         st = ST_CONF;    er = ER_NOID;
      end else if (!r.cred) begin
         st = ST_CONF;    er = ER_NOCRED;
      end else begin
         blk = 1'b0;
      end
      if (blk) begin
         if (clear) r = f_drop(r);
         r = f_go(r, st, er);
      end
      r.acc = !blk;
      return r;
   endfunction

   function automatic sess_type f_evaluate(sess_type s, cfg_type a);
      sess_type r;
      r = f_prereq(s, 1'b1, a);
      if (r.acc && !r.sup && r.st != ST_REQ && r.st != ST_CONNECTING &&
          r.st != ST_AUTHING && r.st != ST_BACKOFF) begin
         r = f_go(r, ST_CONF, ER_NONE);
      end
      return r;
   endfunction

   function automatic sess_type f_request(sess_type s, cfg_type a);
      sess_type r;
      r = f_prereq(s, 1'b0, a);
      if (r.acc && !r.sup) begin
         r.pend = 1'b1;
         r      = f_go(r, ST_REQ, ER_NONE);
      end
      return r;
   endfunction

   function automatic sess_type f_fail(sess_type s, logic [3:0] e, cfg_type a,
                                       logic [7:0] attempt);
      sess_type r;
      logic     fatal;
      logic     retry;
      fatal = (e == ER_AUTH) || (e == ER_NOCRED) || (e == ER_NOID) ||
              (e == ER_INVALID) || (e == ER_INTERNAL);
      retry = (e >= ER_DNS && e <= ER_TLS) || (e >= ER_EXPIRED && e <= ER_PROTOCOL);
      r = f_drop(s);
      priority if (fatal) begin
         r = f_go(r, ST_ERROR, e);
      end else if (!(r.net && r.inet)) begin
         r = f_evaluate(r, a);
      end else if (retry && attempt < a.lim) begin
         r.bo = 1'b1;
         r    = f_go(r, ST_BACKOFF, e);
      end else begin
         r = f_go(r, ST_DEGRADED, e);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // event decision
   // ---------------------------------------------------------------------
   always_comb begin
      sess_type s;
      cfg_type  a;
      logic     acc;
      s            = sess_ff;
      s.nb         = 2'd0;
      s.acc        = 1'b0;
      s.bo         = 1'b0;
      a            = act_ff;
      acc          = 1'b0;
      dec_cnt_sel  = CNT_NONE;
      dec_clr      = 1'b0;
      dec_tick_clr = 1'b0;
      unique case (evt_ff.opcode)
         OP_TICK: begin
            if (s.st == ST_BACKOFF && due_ff != 32'd0 && evt_ff.now_ms >= due_ff) begin
               dec_tick_clr = 1'b1;
               if (s.net && s.inet && f_cfgd(a) && s.devid && s.cred) begin
                  s.pend = 1'b1;
                  s      = f_go(s, ST_REQ, ER_NONE);
               end else begin
                  s = f_evaluate(s, a);
               end
            end
         end
         OP_LINK: begin
            if (s.net != evt_ff.flag_first || s.inet != evt_ff.flag_second) begin
               s.nb = s.nb + 2'd1;
            end
            s.net  = evt_ff.flag_first;
            s.inet = evt_ff.flag_second;
            if (!evt_ff.flag_first || !evt_ff.flag_second) begin
               s = f_drop(s);
               s = f_evaluate(s, a);
            end else begin
               s = f_evaluate(s, a);
               if (a.auto_conn && f_cfgd(a) && s.devid && s.cred && !s.sup &&
                   s.st != ST_BACKOFF) begin
                  s = f_request(s, a);
               end
            end
         end
         OP_CRED: begin
            if (s.cred != evt_ff.flag_first) begin
               s.cred = evt_ff.flag_first;
               s.nb   = s.nb + 2'd1;
               if (!evt_ff.flag_first) begin
                  s = f_drop(s);
                  s = f_evaluate(s, a);
               end else begin
                  s = f_evaluate(s, a);
                  if (f_auto_ok(s, a)) s = f_request(s, a);
               end
            end
         end
         OP_DEVID: begin
            s.devid = evt_ff.flag_first;
            s.nb    = s.nb + 2'd1;
            s       = f_evaluate(s, a);
            if (evt_ff.flag_first && f_auto_ok(s, a)) s = f_request(s, a);
         end
         OP_REQUEST: begin
            s   = f_request(s, a);
            acc = s.acc;
         end
         OP_BEGIN: begin
            if (s.pend && s.st == ST_REQ) begin
               s           = f_drop(s);
               dec_cnt_sel = CNT_CONN;
               s           = f_go(s, ST_CONNECTING, ER_NONE);
               acc         = 1'b1;
            end
         end
         OP_UP: begin
            if (s.st == ST_CONNECTING) begin
               s.link = 1'b1;
               s      = f_go(s, ST_AUTHING, ER_NONE);
            end
         end
         OP_AUTH: begin
            if (s.st == ST_AUTHING && s.link) begin
               s.auth      = 1'b1;
               s.sup       = 1'b1;
               dec_clr     = 1'b1;
               dec_cnt_sel = CNT_SESS;
               s           = f_go(s, ST_READY, ER_NONE);
            end
         end
         OP_FAIL: begin
            dec_cnt_sel = CNT_FAIL;
            s           = f_fail(s, evt_ff.error_code, a, attempt_ff);
         end
         OP_DISC: begin
            s       = f_drop(s);
            dec_clr = 1'b1;
            if (!(s.net && s.inet)) begin
               s = f_evaluate(s, a);
            end else if (evt_ff.error_code == ER_NONE) begin
               s = f_go(s, ST_CONF, evt_ff.error_code);
            end else begin
               s = f_go(s, ST_DEGRADED, evt_ff.error_code);
            end
         end
         OP_EXPIRE: begin
            if (s.sup) begin
               dec_cnt_sel = CNT_FAIL;
               s           = f_fail(s, ER_EXPIRED, a, attempt_ff);
            end
         end
         OP_APPLY: begin
            // normalize staged settings into the active copy
            a.en        = staged.en;
            a.auto_conn = staged.auto_conn;
            a.url       = staged.url;
            a.lim       = (staged.lim != 8'd0) ? staged.lim : DEF_LIMIT;
            a.base      = (staged.base != 32'd0) ? staged.base : DEF_BASE;
            a.max_d     = (staged.max_d < a.base) ? a.base : staged.max_d;
            s           = f_drop(s);
            dec_clr     = 1'b1;
            s.nb        = s.nb + 2'd1;
            s           = f_evaluate(s, a);
            if (a.en && f_auto_ok(s, a)) s = f_request(s, a);
            acc = f_cfgd(a);
         end
         default: begin
         end
      endcase
      s.acc    = acc;
      dec_sess = s;
      dec_act  = a;
   end

   // ---------------------------------------------------------------------
   // ALU steering
   // ---------------------------------------------------------------------
   always_comb begin
      alu_req = '0;
      unique case (seq_ff)
         SEQ_GEN: begin
            alu_req.a = {1'b0, gen_ff};
            alu_req.b = {31'd0, sess_ff.nb};
         end
         SEQ_CNT: begin
            unique case (cnt_sel_ff)
               CNT_FAIL: alu_req.a = {1'b0, fail_ff};
               CNT_CONN: alu_req.a = {1'b0, conn_ff};
               CNT_SESS: alu_req.a = {1'b0, stot_ff};
               default:  alu_req.a = '0;
            endcase
            alu_req.b = 33'd1;
         end
         SEQ_DBL: begin
            alu_req.a = work_d_ff;
            alu_req.b = work_d_ff;
            alu_req.c = {1'b0, act_ff.max_d};
         end
         SEQ_DUE: begin
            alu_req.a = {1'b0, time_ff};
            alu_req.b = {1'b0, delay_ff};
         end
         default: alu_req = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      seq_in      = seq_ff;
      evt_in      = evt_ff;
      act_in      = act_ff;
      sess_in     = sess_ff;
      gen_in      = gen_ff;
      fail_in     = fail_ff;
      conn_in     = conn_ff;
      stot_in     = stot_ff;
      attempt_in  = attempt_ff;
      delay_in    = delay_ff;
      due_in      = due_ff;
      time_in     = time_ff;
      cnt_sel_in  = cnt_sel_ff;
      work_d_in   = work_d_ff;
      work_cnt_in = work_cnt_ff;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (start) begin
               evt_in = evt;
               seq_in = SEQ_DECIDE;
            end
         end
         SEQ_DECIDE: begin
            sess_in    = dec_sess;
            act_in     = dec_act;
            cnt_sel_in = dec_cnt_sel;
            if (evt_ff.opcode == OP_TICK) time_in = evt_ff.now_ms;
            if (dec_clr) begin
               attempt_in = 8'd0;
               delay_in   = 32'd0;
               due_in     = 32'd0;
            end
            if (dec_tick_clr) begin
               delay_in = 32'd0;
               due_in   = 32'd0;
            end
            if (dec_sess.bo) begin
               attempt_in  = attempt_ff + 8'd1;
               work_cnt_in = attempt_ff + 8'd1;
               work_d_in   = {1'b0, dec_act.base};
            end
            seq_in = SEQ_GEN;
         end
         SEQ_GEN: begin
            gen_in = alu_rsp.sum[31:0];
            seq_in = SEQ_CNT;
         end
         SEQ_CNT: begin
            unique case (cnt_sel_ff)
               CNT_FAIL: fail_in = alu_rsp.sum[31:0];
               CNT_CONN: conn_in = alu_rsp.sum[31:0];
               CNT_SESS: stot_in = alu_rsp.sum[31:0];
               default: begin
               end
            endcase
            seq_in = sess_ff.bo ? SEQ_DBL : SEQ_DONE;
         end
         SEQ_DBL: begin
            // double while attempts remain and the cap is not reached
            if (work_cnt_ff > 8'd1 && alu_rsp.lt) begin
               work_d_in   = alu_rsp.sum;
               work_cnt_in = work_cnt_ff - 8'd1;
            end else begin
               delay_in = (alu_rsp.lt || alu_rsp.eq) ? work_d_ff[31:0] : act_ff.max_d;
               seq_in   = SEQ_DUE;
            end
         end
         SEQ_DUE: begin
            due_in = alu_rsp.sum[31:0];
            seq_in = SEQ_DONE;
         end
         SEQ_DONE: begin
            if (out_free) seq_in = SEQ_IDLE;
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      evt_ff      <= evt_in;
      cnt_sel_ff  <= cnt_sel_in;
      work_d_ff   <= work_d_in;
      work_cnt_ff <= work_cnt_in;
      if (reset) begin
         seq_ff        <= SEQ_IDLE;
         act_ff        <= cfg_type'({1'b1, 1'b1, DEF_LIMIT, DEF_BASE, DEF_MAX, 1'b0});
         sess_ff       <= sess_type'({ST_UNCONF, ER_NOTCONF, 12'd0});
         gen_ff        <= 32'd1;
         fail_ff       <= 32'd0;
         conn_ff       <= 32'd0;
         stot_ff       <= 32'd0;
         attempt_ff    <= 8'd0;
         delay_ff      <= 32'd0;
         due_ff        <= 32'd0;
         time_ff       <= 32'd0;
      end else begin
         seq_ff     <= seq_in;
         act_ff     <= act_in;
         sess_ff    <= sess_in;
         gen_ff     <= gen_in;
         fail_ff    <= fail_in;
         conn_ff    <= conn_in;
         stot_ff    <= stot_in;
         attempt_ff <= attempt_in;
         delay_ff   <= delay_in;
         due_ff     <= due_in;
         time_ff    <= time_in;
      end
   end

   assign ready     = (seq_ff == SEQ_IDLE);
   assign res_valid = (seq_ff == SEQ_DONE);

   always_comb begin
      res.session_state  = sess_ff.st;
      res.last_error     = sess_ff.er;
      res.generation     = gen_ff;
      res.accepted       = sess_ff.acc;
      res.is_ready       = (sess_ff.st == ST_READY) && sess_ff.sup && sess_ff.auth &&
                           sess_ff.link;
      res.should_connect = (sess_ff.st == ST_REQ) && sess_ff.pend;
      res.retry_count    = attempt_ff;
      res.retry_wait_ms  = delay_ff;
      res.retry_due_time = due_ff;
      res.failures       = fail_ff;
      res.connects       = conn_ff;
      res.sessions       = stot_ff;
   end

`ifndef SYNTHESIS
   a_attempt_lim: assert property (@(posedge clock) disable iff (reset)
      attempt_ff <= act_ff.lim)
      else $error("retry attempt exceeds active limit");

   a_settings_norm: assert property (@(posedge clock) disable iff (reset)
      act_ff.base != 32'd0 && act_ff.max_d >= act_ff.base)
      else $error("active backoff settings not normalized");

   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      seq_ff == SEQ_DUE |-> delay_ff != 32'd0 && delay_ff <= act_ff.max_d)
      else $error("backoff delay outside base..cap");
`endif

endmodule

>>> hdl/session_link_manager_with_backoff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_link_manager_with_backoff - connection session manager
// Event-driven session machine with error tracking, generation counter,
// exponential retry backoff and staged settings applied on request.
// ----------------------------------------------------------------------------
// One event beat in gives exactly one status beat out. Events are handled
// one at a time by a small sequencer over a shared 33-bit add/compare unit:
// each beat steps through decide, generation add, total add and hand-off
// to the status register, and the next event is taken once the sequencer
// is back at idle; a failure that enters backoff adds the doubling steps
// of the delay and a due-time add before the hand-off. req_tready is low
// while an event is in flight; a finished status beat waits in the output
// register, and until it is taken the next result waits at hand-off.
// Configuration writes land in staged registers and take effect only on the
// apply-config event, which normalizes them (limit 0 -> 3, base 0 -> 1000,
// cap raised to base). csr_ready is always high; write only while idle.
module session_link_manager_with_backoff (
   input  logic                            clock,
   input  logic                            reset,
   // event channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] flag_first, [1] flag_second, [5:2] error_code, [37:6] now_ms,
   // [39:38] zero
   input  logic [slm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [3:0] opcode
   input  logic [3:0]                      req_tuser,
   // status channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] session_state, [7:4] last_error, [39:8] generation, [40] accepted,
   // [41] is_ready, [42] should_connect, [50:43] retry_count,
   // [82:51] retry_wait_ms, [114:83] retry_due_time, [146:115] failures,
   // [178:147] connects, [210:179] sessions, [215:211] zero
   output logic [slm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [slm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_data
);
   import slm_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   evt_type                 evt;
   rsp_type                 res;
   logic                    core_ready;
   logic                    res_valid;
   logic                    out_free;
   logic                    start;
   logic                    load;

   // accept an event beat only while the sequencer is idle
   assign req_tready = core_ready;
   assign start      = req_tvalid && req_tready;

   assign evt.opcode      = req_tuser;
   assign evt.flag_first  = req_tdata[0];
   assign evt.flag_second = req_tdata[1];
   assign evt.error_code  = req_tdata[5:2];
   assign evt.now_ms      = req_tdata[37:6];

   // staged settings; writes beyond the register list are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENABLE: cfg_in.en        = csr_data[0];
            CSR_AUTO:   cfg_in.auto_conn = csr_data[0];
            CSR_LIMIT:  cfg_in.lim       = csr_data[7:0];
            CSR_BASE:   cfg_in.base      = csr_data;
            CSR_MAX:    cfg_in.max_d     = csr_data;
            CSR_URL:    cfg_in.url       = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   slm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .evt       (evt),
      .staged    (cfg_ff),
      .out_free  (out_free),
      .ready     (core_ready),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register: load when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = res_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, res.sessions, res.connects, res.failures,
                         res.retry_due_time, res.retry_wait_ms, res.retry_count,
                         res.should_connect, res.is_ready, res.accepted,
                         res.generation, res.last_error, res.session_state};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= cfg_type'({1'b1, 1'b1, DEF_LIMIT, DEF_BASE, DEF_MAX, 1'b0});
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/sv/slm_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_status_checker - status predictor and scoreboard for the session manager
// Watches the event, status and register channels. It keeps its own copy of
// the session machine and settings, computes the status of each accepted
// event, and compares every status beat with the oldest prediction.
// ----------------------------------------------------------------------------
module slm_status_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [slm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [3:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [slm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [slm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_data,
   output int unsigned                     fail_count,
   output int unsigned                     in_flight,
   output int unsigned                     checked
);
   import slm_pkg::*;

   // staged and active settings
   logic        stg_en, stg_auto, stg_url;
   logic [7:0]  stg_lim;
   logic [31:0] stg_base, stg_max;
   logic        act_en, act_auto, act_url;
   logic [7:0]  act_lim;
   logic [31:0] act_base, act_max;

   // session machine
   logic [3:0]  sess_st, sess_err;
   logic [31:0] gen_ctr;
   logic        net_ok, inet_ok, cred_ready, dev_id, conn_pending;
   logic        link_ok, auth_done, sess_live;
   logic [7:0]  retry_num;
   logic [31:0] wait_ms, due_ms, last_ms;
   logic [31:0] fail_cnt, conn_cnt, sess_cnt;

   rsp_type status_q[$];

   function automatic void clear_model();
      stg_en = 1'b1; stg_auto = 1'b1; stg_lim = DEF_LIMIT;
      stg_base = DEF_BASE; stg_max = DEF_MAX; stg_url = 1'b0;
      act_en = 1'b1; act_auto = 1'b1; act_lim = DEF_LIMIT;
      act_base = DEF_BASE; act_max = DEF_MAX; act_url = 1'b0;
      sess_st = ST_UNCONF; sess_err = ER_NOTCONF; gen_ctr = 32'd1;
      net_ok = 1'b0; inet_ok = 1'b0; cred_ready = 1'b0; dev_id = 1'b0;
      conn_pending = 1'b0; link_ok = 1'b0; auth_done = 1'b0; sess_live = 1'b0;
      retry_num = 8'd0; wait_ms = 32'd0; due_ms = 32'd0; last_ms = 32'd0;
      fail_cnt = 32'd0; conn_cnt = 32'd0; sess_cnt = 32'd0;
   endfunction

   // any change of state or error advances the generation
   function automatic void move_to(logic [3:0] s, logic [3:0] e);
      if (sess_st != s || sess_err != e) begin
         sess_st  = s;
         sess_err = e;
         gen_ctr++;
      end
   endfunction

   function automatic bit cfg_ok();
      return !act_en || act_url;
   endfunction

   function automatic bit link_both();
      return net_ok && inet_ok;
   endfunction

   function automatic bit ids_ok();
      return dev_id && cred_ready;
   endfunction

   function automatic void tear_down();
      conn_pending = 1'b0;
      link_ok      = 1'b0;
      auth_done    = 1'b0;
      sess_live    = 1'b0;
   endfunction

   function automatic void clear_retry();
      retry_num = 8'd0;
      wait_ms   = 32'd0;
      due_ms    = 32'd0;
   endfunction

   // double from the base until the cap is reached, then clamp to the cap
   function automatic logic [31:0] backoff_ms(logic [7:0] attempt);
      logic [33:0] d;
      logic [7:0]  k;
      d = (act_base != 32'd0) ? {2'b00, act_base} : {2'b00, DEF_BASE};
      k = attempt;
      while (k > 8'd1 && d < {2'b00, act_max}) begin
         d = d << 1;
         k--;
      end
      if (act_max != 32'd0 && d > {2'b00, act_max})
         d = {2'b00, act_max};
      return d[31:0];
   endfunction

   function automatic bit is_retryable(logic [3:0] e);
      return (e >= ER_DNS && e <= ER_TLS) || (e >= ER_EXPIRED && e <= ER_PROTOCOL);
   endfunction

   // walk the prerequisite chain; on a missing one, park in its blocking state
   function automatic bit gate_check(bit clr);
      logic [3:0] s, e;
      if (!act_en) begin
         s = ST_IDLE;    e = ER_NONE;
      end else if (!cfg_ok()) begin
         s = ST_UNCONF;  e = ER_NOTCONF;
      end else if (!net_ok) begin
         s = ST_OFFLINE; e = ER_NONET;
      end else if (!inet_ok) begin
         s = ST_OFFLINE; e = ER_NOINET;
      end else if (!dev_id) begin
         s = ST_CONF;    e = ER_NOID;
      end else if (!cred_ready) begin
         s = ST_CONF;    e = ER_NOCRED;
      end else begin
         return 1'b1;
      end
      if (clr)
         tear_down();
      move_to(s, e);
      return 1'b0;
   endfunction

   function automatic void reevaluate();
      if (!gate_check(1'b1))
         return;
      if (!sess_live && sess_st != ST_REQ && sess_st != ST_CONNECTING &&
          sess_st != ST_AUTHING && sess_st != ST_BACKOFF)
         move_to(ST_CONF, ER_NONE);
   endfunction

   function automatic bit ask_connect();
      if (!gate_check(1'b0))
         return 1'b0;
      if (sess_live)
         return 1'b1;
      conn_pending = 1'b1;
      move_to(ST_REQ, ER_NONE);
      return 1'b1;
   endfunction

   function automatic bit auto_go();
      return act_auto && cfg_ok() && link_both() && ids_ok();
   endfunction

   function automatic void take_failure(logic [3:0] e);
      fail_cnt++;
      tear_down();
      // fatal codes park in error without retry
      if (e == ER_AUTH || e == ER_NOCRED || e == ER_NOID || e == ER_INVALID ||
          e == ER_INTERNAL) begin
         move_to(ST_ERROR, e);
         return;
      end
      if (!link_both()) begin
         reevaluate();
         return;
      end
      if (is_retryable(e) && retry_num < act_lim) begin
         retry_num++;
         wait_ms = backoff_ms(retry_num);
         due_ms  = last_ms + wait_ms;
         move_to(ST_BACKOFF, e);
         return;
      end
      move_to(ST_DEGRADED, e);
   endfunction

   function automatic rsp_type predict_status(evt_type ev);
      rsp_type r;
      bit      acc;
      bit      chg;
      acc = 1'b0;
      case (ev.opcode)
         OP_TICK: begin
            last_ms = ev.now_ms;
            // a due time of zero never ends the backoff
            if (sess_st == ST_BACKOFF && due_ms != 32'd0 && ev.now_ms >= due_ms) begin
               wait_ms = 32'd0;
               due_ms  = 32'd0;
               if (link_both() && cfg_ok() && ids_ok()) begin
                  conn_pending = 1'b1;
                  move_to(ST_REQ, ER_NONE);
               end else begin
                  reevaluate();
               end
            end
         end
         OP_LINK: begin
            chg = (net_ok != ev.flag_first) || (inet_ok != ev.flag_second);
            net_ok  = ev.flag_first;
            inet_ok = ev.flag_second;
            if (chg)
               gen_ctr++;
            if (!ev.flag_first || !ev.flag_second) begin
               tear_down();
               reevaluate();
            end else begin
               reevaluate();
               if (act_auto && cfg_ok() && ids_ok() && !sess_live && sess_st != ST_BACKOFF)
                  void'(ask_connect());
            end
         end
         OP_CRED: begin
            if (cred_ready != ev.flag_first) begin
               cred_ready = ev.flag_first;
               gen_ctr++;
               if (!ev.flag_first) begin
                  tear_down();
                  reevaluate();
               end else begin
                  reevaluate();
                  if (auto_go())
                     void'(ask_connect());
               end
            end
         end
         OP_DEVID: begin
            // bumps even when the value does not change
            dev_id = ev.flag_first;
            gen_ctr++;
            reevaluate();
            if (ev.flag_first && auto_go())
               void'(ask_connect());
         end
         OP_REQUEST: acc = ask_connect();
         OP_BEGIN: begin
            if (conn_pending && sess_st == ST_REQ) begin
               tear_down();
               conn_cnt++;
               move_to(ST_CONNECTING, ER_NONE);
               acc = 1'b1;
            end
         end
         OP_UP: begin
            if (sess_st == ST_CONNECTING) begin
               link_ok = 1'b1;
               move_to(ST_AUTHING, ER_NONE);
            end
         end
         OP_AUTH: begin
            if (sess_st == ST_AUTHING && link_ok) begin
               auth_done = 1'b1;
               sess_live = 1'b1;
               clear_retry();
               sess_cnt++;
               move_to(ST_READY, ER_NONE);
            end
         end
         OP_FAIL: take_failure(ev.error_code);
         OP_DISC: begin
            tear_down();
            clear_retry();
            if (!link_both())
               reevaluate();
            else
               move_to(ev.error_code == ER_NONE ? ST_CONF : ST_DEGRADED, ev.error_code);
         end
         OP_EXPIRE: begin
            if (sess_live)
               take_failure(ER_EXPIRED);
         end
         OP_APPLY: begin
            // copy staged settings, normalizing zero or inconsistent values
            act_en   = stg_en;
            act_auto = stg_auto;
            act_url  = stg_url;
            act_lim  = (stg_lim != 8'd0) ? stg_lim : DEF_LIMIT;
            act_base = (stg_base != 32'd0) ? stg_base : DEF_BASE;
            act_max  = (stg_max < act_base) ? act_base : stg_max;
            tear_down();
            clear_retry();
            gen_ctr++;
            reevaluate();
            if (act_en && auto_go())
               void'(ask_connect());
            acc = cfg_ok();
         end
         default: ;
      endcase
      r.session_state  = sess_st;
      r.last_error     = sess_err;
      r.generation     = gen_ctr;
      r.accepted       = acc;
      r.is_ready       = (sess_st == ST_READY) && sess_live && auth_done && link_ok;
      r.should_connect = (sess_st == ST_REQ) && conn_pending;
      r.retry_count    = retry_num;
      r.retry_wait_ms  = wait_ms;
      r.retry_due_time = due_ms;
      r.failures       = fail_cnt;
      r.connects       = conn_cnt;
      r.sessions       = sess_cnt;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      evt_type ev;
      rsp_type want;
      if (reset) begin
         clear_model();
         status_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE: stg_en   = csr_data[0];
               CSR_AUTO:   stg_auto = csr_data[0];
               CSR_LIMIT:  stg_lim  = csr_data[7:0];
               CSR_BASE:   stg_base = csr_data;
               CSR_MAX:    stg_max  = csr_data;
               CSR_URL:    stg_url  = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            ev.opcode      = req_tuser;
            ev.flag_first  = req_tdata[0];
            ev.flag_second = req_tdata[1];
            ev.error_code  = req_tdata[5:2];
            ev.now_ms      = req_tdata[37:6];
            status_q.push_back(predict_status(ev));
         end
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (status_q.size() == 0) begin
               $error("status beat with no event outstanding");
               fail_count++;
            end else begin
               want = status_q.pop_front();
               check_field("session_state",  32'(want.session_state),
                           32'(rsp_tdata[3:0]));
               check_field("last_error",     32'(want.last_error), 32'(rsp_tdata[7:4]));
               check_field("generation",     want.generation,     rsp_tdata[39:8]);
               check_field("accepted",       32'(want.accepted),  32'(rsp_tdata[40]));
               check_field("is_ready",       32'(want.is_ready),  32'(rsp_tdata[41]));
               check_field("should_connect", 32'(want.should_connect),
                           32'(rsp_tdata[42]));
               check_field("retry_count",    32'(want.retry_count),
                           32'(rsp_tdata[50:43]));
               check_field("retry_wait_ms",  want.retry_wait_ms,  rsp_tdata[82:51]);
               check_field("retry_due_time", want.retry_due_time, rsp_tdata[114:83]);
               check_field("failures",       want.failures,       rsp_tdata[146:115]);
               check_field("connects",       want.connects,       rsp_tdata[178:147]);
               check_field("sessions",       want.sessions,       rsp_tdata[210:179]);
            end
         end
      end
      in_flight = status_q.size();
   end

endmodule

>>> tb/sv/session_link_manager_with_backoff_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_link_manager_with_backoff_tb - session manager testbench
// Drives event beats and register writes into the session manager while a
// separate checker predicts and compares every status beat. A directed
// opening walks the session life cycle and its corner cases, then random
// session scripts and noise run under several setting phases.
// ----------------------------------------------------------------------------
module session_link_manager_with_backoff_tb;
   import slm_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned PHASE_EVENTS = 232;
   localparam int unsigned NUM_PHASES   = 7;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [3:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [31:0]            csr_data;

   int unsigned fail_count;
   int unsigned in_flight;
   int unsigned checked;
   int unsigned cycles = 0;
   int unsigned n_sent = 0;
   logic        no_idle = 1'b0;   // high during the stretch without idling
   logic [31:0] wall_ms = 32'd0;  // running millisecond clock for ticks

   session_link_manager_with_backoff u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   slm_status_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .in_flight  (in_flight),
      .checked    (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("session_link_manager_with_backoff_tb: FAIL");
         $finish;
      end
   end

   // stall the status side at random, except during the steady stretch
   always @(negedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(99) >= 15);
   end

   // Send one event beat. Entered and left at a falling edge; valid stays
   // high between back-to-back beats and drops only for an idle gap.
   task automatic send_evt(input logic [3:0] op, input logic f1, input logic f2,
                           input logic [3:0] ec, input logic [31:0] now);
      if (!no_idle && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 40);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, now, ec, f2, f1};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (op <= OP_APPLY)
         n_sent++;
   endtask

   // event whose other fields are don't-care: fill them at random
   task automatic send_op(input logic [3:0] op, input logic f1);
      send_evt(op, f1, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom);
   endtask

   task automatic send_noise();
      send_evt(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom);
   endtask

   // advance the millisecond clock, mostly in small steps, now and then jump
   task automatic tick_ahead();
      case ($urandom_range(0, 19))
         0:       wall_ms = $urandom;
         1, 2:    wall_ms = wall_ms + $urandom_range(0, 60000);
         default: wall_ms = wall_ms + $urandom_range(0, 4000);
      endcase
      send_evt(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               4'($urandom_range(0, 15)), wall_ms);
   endtask

   function automatic logic [3:0] fail_reason();
      logic [3:0] retry_codes [7];
      retry_codes = '{ER_DNS, ER_CONNECT, ER_TLS, ER_EXPIRED, ER_RATE, ER_SERVER,
                      ER_PROTOCOL};
      if ($urandom_range(0, 9) < 6)
         return retry_codes[3'($urandom_range(0, 6))];
      return 4'($urandom_range(0, 15));
   endfunction

   // hold until every status beat is back, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_settings(input logic en, input logic auto_conn,
                                input logic [7:0] lim, input logic [31:0] base,
                                input logic [31:0] cap, input logic url);
      drain();
      write_reg(CSR_ENABLE, {31'd0, en});
      write_reg(CSR_AUTO,   {31'd0, auto_conn});
      write_reg(CSR_LIMIT,  {24'd0, lim});
      write_reg(CSR_BASE,   base);
      write_reg(CSR_MAX,    cap);
      write_reg(CSR_URL,    {31'd0, url});
      csr_valid <= 1'b0;
   endtask

   // One well-formed session script with random content: raise the
   // prerequisites, then mix connects, failures, expiries, disconnects,
   // clock ticks and the odd stray event.
   task automatic run_session();
      int unsigned steps;
      if ($urandom_range(0, 9) != 0)
         send_evt(OP_LINK, 1'b1, 1'b1, 4'($urandom_range(0, 15)), $urandom);
      else
         send_evt(OP_LINK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  4'($urandom_range(0, 15)), $urandom);
      send_op(OP_CRED, $urandom_range(0, 9) != 0);
      send_op(OP_DEVID, $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 4) == 0)
         send_op(OP_APPLY, 1'($urandom_range(0, 1)));
      steps = $urandom_range(4, 14);
      repeat (steps) begin
         case ($urandom_range(0, 11))
            0, 1, 2: begin
               send_op(OP_REQUEST, 1'($urandom_range(0, 1)));
               send_op(OP_BEGIN, 1'($urandom_range(0, 1)));
               send_op(OP_UP, 1'($urandom_range(0, 1)));
               // skip the auth now and then so retries pile up
               if ($urandom_range(0, 3) != 0)
                  send_op(OP_AUTH, 1'($urandom_range(0, 1)));
            end
            3, 4: send_evt(OP_FAIL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           fail_reason(), $urandom);
            5:    send_op(OP_EXPIRE, 1'($urandom_range(0, 1)));
            6:    send_evt(OP_DISC, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 1) ? ER_NONE : 4'($urandom_range(0, 15)),
                           $urandom);
            7, 8, 9: repeat ($urandom_range(1, 3)) tick_ahead();
            10:   send_noise();
            default: begin
               case ($urandom_range(0, 2))
                  0:       send_evt(OP_LINK, 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)),
                                    4'($urandom_range(0, 15)), $urandom);
                  1:       send_op(OP_CRED, 1'($urandom_range(0, 1)));
                  default: send_op(OP_DEVID, 1'($urandom_range(0, 1)));
               endcase
            end
         endcase
      end
   endtask

   task automatic run_phase(input int unsigned target);
      int unsigned start;
      start = n_sent;
      while (n_sent - start < target) begin
         if ($urandom_range(0, 9) < 7)
            run_session();
         else
            repeat ($urandom_range(1, 4)) send_noise();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_TICK;
      csr_valid  = 1'b0;
      csr_index  = CSR_ENABLE;
      csr_data   = 32'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: unconfigured gateway after reset
      send_evt(OP_TICK, 1'b0, 1'b0, ER_NONE, 32'd0);
      send_evt(4'd12, 1'b1, 1'b1, ER_INTERNAL, 32'hFFFF_FFFF);   // unused opcode
      send_evt(4'd15, 1'b0, 1'b1, ER_DNS, 32'h5555_AAAA);        // unused opcode
      send_evt(OP_LINK, 1'b1, 1'b1, ER_NONE, 32'd0);
      send_op(OP_APPLY, 1'b0);                                   // rejected: no address

      // directed: full life cycle once the address is set
      load_settings(1'b1, 1'b1, DEF_LIMIT, DEF_BASE, DEF_MAX, 1'b1);
      send_op(OP_APPLY, 1'b0);
      send_op(OP_CRED, 1'b1);
      send_op(OP_DEVID, 1'b1);           // auto-connect raises the request
      send_op(OP_DEVID, 1'b1);           // same value still advances generation
      send_op(OP_REQUEST, 1'b0);
      send_op(OP_BEGIN, 1'b0);
      send_op(OP_UP, 1'b0);
      send_op(OP_AUTH, 1'b0);
      // due time wraps to zero: backoff must not end on any tick
      send_evt(OP_TICK, 1'b0, 1'b0, ER_NONE, 32'hFFFF_FC18);
      send_evt(OP_FAIL, 1'b0, 1'b0, ER_CONNECT, 32'd0);
      send_evt(OP_TICK, 1'b0, 1'b0, ER_NONE, 32'hFFFF_FFFF);
      send_evt(OP_LINK, 1'b1, 1'b0, ER_NONE, 32'd0);             // internet lost
      send_evt(OP_LINK, 1'b1, 1'b1, ER_NONE, 32'd0);
      send_op(OP_BEGIN, 1'b0);
      send_op(OP_UP, 1'b0);
      send_op(OP_AUTH, 1'b0);
      send_op(OP_EXPIRE, 1'b0);          // expiry retries through backoff
      send_evt(OP_TICK, 1'b0, 1'b0, ER_NONE, 32'd2000);
      send_evt(OP_DISC, 1'b0, 1'b0, ER_RATE, 32'd0);
      send_evt(OP_FAIL, 1'b1, 1'b1, ER_AUTH, 32'd0);             // fatal code

      // random: one phase per setting, each opened by an apply
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: load_settings(1'b1, 1'b1, 8'd3, 32'd1000, 32'd10000, 1'b1);
            1: load_settings(1'b1, 1'b1, 8'd0, 32'd0, 32'd0, 1'b1);
            2: load_settings(1'b1, 1'b1, 8'd255, 32'd1, 32'hFFFF_FFFF, 1'b1);
            3: load_settings(1'b1, 1'b0, 8'd1, 32'hFFFF_FFFF, 32'd5, 1'b1);
            4: load_settings(1'b0, 1'b1, 8'd7, 32'd500, 32'd4000, 1'b0);
            5: load_settings(1'b1, 1'b1, 8'd2, 32'd250, 32'd3000, 1'b0);
            default: load_settings($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                                   8'($urandom_range(0, 255)),
                                   $urandom_range(0, 1) ? 32'($urandom_range(1, 5000))
                                                        : 32'($urandom),
                                   $urandom_range(0, 20000), $urandom_range(0, 4) != 0);
         endcase
         // run the long-cap phase with no idling on either side
         no_idle = (ph == 3);
         send_op(OP_APPLY, 1'($urandom_range(0, 1)));
         run_phase(PHASE_EVENTS);
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      while (in_flight != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      $display("Run covered %0d events over %0d setting phases plus a directed opening,",
               n_sent, NUM_PHASES);
      $display("with %0d status beats compared and %0d mismatches.", checked, fail_count);
      if (fail_count == 0)
         $display("session_link_manager_with_backoff_tb: PASS");
      else
         $display("session_link_manager_with_backoff_tb: FAIL");
      $finish;
   end

endmodule
